// ----- hw/rtl/gear_ratio_detector_top_macros.svh -----
// Assertion macros used by grd_decide.
`ifndef GEAR_RATIO_DETECTOR_TOP_MACROS_SVH
`define GEAR_RATIO_DETECTOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked only outside reset.
`define GRD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define GRD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GRD_ASSERT(lbl, prop, msg)
`define GRD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/grd_pkg.sv -----
`timescale 1ns / 1ps
package grd_pkg;

	localparam int CFG_W      = 16;
	localparam int TIME_W     = 32;
	localparam int GEAR_W     = 3;
	localparam int SPEED_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int RATIO_FRAC = 12;
	localparam int SPEED_FRAC = 16;
	localparam int SHAFT_MIN  = 100;
	localparam int WHEEL_MIN  = 10;

	localparam logic [SPEED_W-1:0] SPEED_MAX = 8'd255;

	localparam logic [GEAR_W-1:0] GEAR_NEUTRAL = 3'd0;
	localparam logic [GEAR_W-1:0] GEAR_REVERSE = 3'd1;
	localparam logic [GEAR_W-1:0] GEAR_FIRST   = 3'd2;
	localparam logic [GEAR_W-1:0] GEAR_SECOND  = 3'd3;
	localparam logic [GEAR_W-1:0] GEAR_THIRD   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_RATIO_REVERSE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_FIRST   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_SECOND  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_THIRD   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_TOL     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE   = 3'd6;

	localparam logic [CFG_W-1:0] RST_RATIO_REVERSE = 16'd14090;
	localparam logic [CFG_W-1:0] RST_RATIO_FIRST   = 16'd14090;
	localparam logic [CFG_W-1:0] RST_RATIO_SECOND  = 16'd9052;
	localparam logic [CFG_W-1:0] RST_RATIO_THIRD   = 16'd5612;
	localparam logic [CFG_W-1:0] RST_RATIO_TOL     = 16'd410;
	localparam logic [CFG_W-1:0] RST_TIMEOUT       = 16'd500;
	localparam logic [CFG_W-1:0] RST_SPEED_SCALE   = 16'd4874;

	typedef struct packed {
		logic [CFG_W-1:0] ratio_reverse;
		logic [CFG_W-1:0] ratio_first;
		logic [CFG_W-1:0] ratio_second;
		logic [CFG_W-1:0] ratio_third;
		logic [CFG_W-1:0] ratio_tolerance;
		logic [CFG_W-1:0] stability_timeout_ms;
		logic [CFG_W-1:0] speed_scale;
	} cfg_t;

	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic commit;
	} pipe_ctrl_t;

endpackage

// ----- hw/rtl/grd_in_if.sv -----
`timescale 1ns / 1ps
interface grd_in_if #(parameter int RPM_BITS = 14) ();
	import grd_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [RPM_BITS-1:0] shaft_rpm;
	logic signed [RPM_BITS-1:0] wheel_rpm;
	logic [TIME_W-1:0]          now_ms;

	modport source(output valid, shaft_rpm, wheel_rpm, now_ms, input ready);
	modport sink(input valid, shaft_rpm, wheel_rpm, now_ms, output ready);
endinterface

// ----- hw/rtl/grd_out_if.sv -----
`timescale 1ns / 1ps
interface grd_out_if ();
	import grd_pkg::*;

	logic               valid;
	logic               ready;
	logic [GEAR_W-1:0]  gear;
	logic               gear_changed;
	logic [SPEED_W-1:0] speed_mph;
	logic               speed_changed;

	modport source(output valid, gear, gear_changed, speed_mph, speed_changed, input ready);
	modport sink(input valid, gear, gear_changed, speed_mph, speed_changed, output ready);
endinterface

// ----- hw/rtl/gear_ratio_detector_top.sv -----
`timescale 1ns / 1ps
// Gear ratio detector. Takes one sample transaction per clock while the result side is
// ready and returns exactly one result transaction per sample, in order. The first
// stage registers the sample, the second runs six parallel 16 x RPM_BITS multipliers
// (four ratio products, the tolerance product and the speed product), the third does
// the ratio compares, the stability timing and the speed rounding and holds the
// result. A stalled result stalls the pipe only as far as it is full. The user must
// write registers through cfg_we/cfg_index/cfg_data only while no sample is in flight;
// the block itself does not enforce this. An index with no register is ignored.
module gear_ratio_detector_top #(
	parameter int RPM_BITS = 14
) (
	input  logic                           clk,
	input  logic                           arst_n,
	grd_in_if.sink                         sample,
	grd_out_if.source                      result,
	input  logic                           cfg_we,
	input  logic [grd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [grd_pkg::CFG_W-1:0]      cfg_data
);
	import grd_pkg::*;

	localparam int PW = CFG_W + RPM_BITS;

	cfg_t       cfg;
	pipe_ctrl_t ctrl;

	logic v_s1_q;
	logic v_s2_q;
	logic out_v_q;
	logic en_s1;
	logic en_s2;
	logic en_out;

	logic signed [RPM_BITS-1:0] shaft_s2;
	logic [RPM_BITS-1:0]        mag_s2;
	logic                       wheel_neg_s2;
	logic                       wheel_pos_s2;
	logic [TIME_W-1:0]          now_s2;
	logic [PW-1:0]              rev_prod_s2;
	logic [PW-1:0]              first_prod_s2;
	logic [PW-1:0]              second_prod_s2;
	logic [PW-1:0]              third_prod_s2;
	logic [PW-1:0]              tol_prod_s2;
	logic [PW-1:0]              speed_prod_s2;

	// advance a stage when the one after it empties or is empty
	assign en_out = !out_v_q || result.ready;
	assign en_s2  = !v_s2_q || en_out;
	assign en_s1  = !v_s1_q || en_s2;

	assign sample.ready = en_s1;
	assign result.valid = out_v_q;

	assign ctrl.load_s1 = sample.valid && en_s1;
	assign ctrl.load_s2 = v_s1_q && en_s2;
	assign ctrl.commit  = v_s2_q && en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q  <= 1'b0;
			v_s2_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en_s1)
				v_s1_q <= sample.valid;
			if (en_s2)
				v_s2_q <= v_s1_q;
			if (en_out)
				out_v_q <= v_s2_q;
		end
	end

	grd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	grd_prod #(.RPM_BITS(RPM_BITS)) u_prod (
		.clk            (clk),
		.cfg            (cfg),
		.ctrl           (ctrl),
		.shaft_rpm      (sample.shaft_rpm),
		.wheel_rpm      (sample.wheel_rpm),
		.now_ms         (sample.now_ms),
		.shaft_s2       (shaft_s2),
		.mag_s2         (mag_s2),
		.wheel_neg_s2   (wheel_neg_s2),
		.wheel_pos_s2   (wheel_pos_s2),
		.now_s2         (now_s2),
		.rev_prod_s2    (rev_prod_s2),
		.first_prod_s2  (first_prod_s2),
		.second_prod_s2 (second_prod_s2),
		.third_prod_s2  (third_prod_s2),
		.tol_prod_s2    (tol_prod_s2),
		.speed_prod_s2  (speed_prod_s2)
	);

	grd_decide #(.RPM_BITS(RPM_BITS)) u_decide (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.ctrl           (ctrl),
		.shaft_s2       (shaft_s2),
		.mag_s2         (mag_s2),
		.wheel_neg_s2   (wheel_neg_s2),
		.wheel_pos_s2   (wheel_pos_s2),
		.now_s2         (now_s2),
		.rev_prod_s2    (rev_prod_s2),
		.first_prod_s2  (first_prod_s2),
		.second_prod_s2 (second_prod_s2),
		.third_prod_s2  (third_prod_s2),
		.tol_prod_s2    (tol_prod_s2),
		.speed_prod_s2  (speed_prod_s2),
		.gear           (result.gear),
		.gear_changed   (result.gear_changed),
		.speed_mph      (result.speed_mph),
		.speed_changed  (result.speed_changed)
	);
endmodule

// ----- hw/rtl/grd_cfg.sv -----
`timescale 1ns / 1ps
module grd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [grd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [grd_pkg::CFG_W-1:0]      cfg_data,
	output grd_pkg::cfg_t                  cfg
);
	import grd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ratio_reverse        <= RST_RATIO_REVERSE;
			cfg_q.ratio_first          <= RST_RATIO_FIRST;
			cfg_q.ratio_second         <= RST_RATIO_SECOND;
			cfg_q.ratio_third          <= RST_RATIO_THIRD;
			cfg_q.ratio_tolerance      <= RST_RATIO_TOL;
			cfg_q.stability_timeout_ms <= RST_TIMEOUT;
			cfg_q.speed_scale          <= RST_SPEED_SCALE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RATIO_REVERSE: cfg_q.ratio_reverse        <= cfg_data;
				REG_RATIO_FIRST:   cfg_q.ratio_first          <= cfg_data;
				REG_RATIO_SECOND:  cfg_q.ratio_second         <= cfg_data;
				REG_RATIO_THIRD:   cfg_q.ratio_third          <= cfg_data;
				REG_RATIO_TOL:     cfg_q.ratio_tolerance      <= cfg_data;
				REG_TIMEOUT:       cfg_q.stability_timeout_ms <= cfg_data;
				REG_SPEED_SCALE:   cfg_q.speed_scale          <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ----- hw/rtl/grd_prod.sv -----
`timescale 1ns / 1ps
module grd_prod #(
	parameter int RPM_BITS = 14
) (
	input  logic                                    clk,
	input  grd_pkg::cfg_t                           cfg,
	input  grd_pkg::pipe_ctrl_t                     ctrl,
	input  logic signed [RPM_BITS-1:0]              shaft_rpm,
	input  logic signed [RPM_BITS-1:0]              wheel_rpm,
	input  logic [grd_pkg::TIME_W-1:0]              now_ms,
	output logic signed [RPM_BITS-1:0]              shaft_s2,
	output logic [RPM_BITS-1:0]                     mag_s2,
	output logic                                    wheel_neg_s2,
	output logic                                    wheel_pos_s2,
	output logic [grd_pkg::TIME_W-1:0]              now_s2,
	output logic [grd_pkg::CFG_W+RPM_BITS-1:0]      rev_prod_s2,
	output logic [grd_pkg::CFG_W+RPM_BITS-1:0]      first_prod_s2,
	output logic [grd_pkg::CFG_W+RPM_BITS-1:0]      second_prod_s2,
	output logic [grd_pkg::CFG_W+RPM_BITS-1:0]      third_prod_s2,
	output logic [grd_pkg::CFG_W+RPM_BITS-1:0]      tol_prod_s2,
	output logic [grd_pkg::CFG_W+RPM_BITS-1:0]      speed_prod_s2
);
	import grd_pkg::*;

	localparam int PW = CFG_W + RPM_BITS;

	logic signed [RPM_BITS-1:0] shaft_s1;
	logic signed [RPM_BITS-1:0] wheel_s1;
	logic [TIME_W-1:0]          now_s1;
	logic [RPM_BITS-1:0]        mag;

	always_ff @(posedge clk) begin
		if (ctrl.load_s1) begin
			shaft_s1 <= shaft_rpm;
			wheel_s1 <= wheel_rpm;
			now_s1   <= now_ms;
		end
	end

	// the most negative value maps onto its own bit pattern, read as unsigned
	assign mag = wheel_s1[RPM_BITS-1] ? RPM_BITS'(-wheel_s1) : RPM_BITS'(wheel_s1);

	always_ff @(posedge clk) begin
		if (ctrl.load_s2) begin
			shaft_s2       <= shaft_s1;
			mag_s2         <= mag;
			wheel_neg_s2   <= wheel_s1[RPM_BITS-1];
			wheel_pos_s2   <= !wheel_s1[RPM_BITS-1] && (wheel_s1 != '0);
			now_s2         <= now_s1;
			rev_prod_s2    <= PW'(cfg.ratio_reverse) * PW'(mag);
			first_prod_s2  <= PW'(cfg.ratio_first) * PW'(mag);
			second_prod_s2 <= PW'(cfg.ratio_second) * PW'(mag);
			third_prod_s2  <= PW'(cfg.ratio_third) * PW'(mag);
			tol_prod_s2    <= PW'(cfg.ratio_tolerance) * PW'(mag);
			speed_prod_s2  <= PW'(cfg.speed_scale) * PW'(mag);
		end
	end
endmodule

// ----- hw/rtl/grd_decide.sv -----
`timescale 1ns / 1ps
`include "gear_ratio_detector_top_macros.svh"
module grd_decide #(
	parameter int RPM_BITS = 14
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  grd_pkg::cfg_t                           cfg,
	input  grd_pkg::pipe_ctrl_t                     ctrl,
	input  logic signed [RPM_BITS-1:0]              shaft_s2,
	input  logic [RPM_BITS-1:0]                     mag_s2,
	input  logic                                    wheel_neg_s2,
	input  logic                                    wheel_pos_s2,
	input  logic [grd_pkg::TIME_W-1:0]              now_s2,
	input  logic [grd_pkg::CFG_W+RPM_BITS-1:0]      rev_prod_s2,
	input  logic [grd_pkg::CFG_W+RPM_BITS-1:0]      first_prod_s2,
	input  logic [grd_pkg::CFG_W+RPM_BITS-1:0]      second_prod_s2,
	input  logic [grd_pkg::CFG_W+RPM_BITS-1:0]      third_prod_s2,
	input  logic [grd_pkg::CFG_W+RPM_BITS-1:0]      tol_prod_s2,
	input  logic [grd_pkg::CFG_W+RPM_BITS-1:0]      speed_prod_s2,
	output logic [grd_pkg::GEAR_W-1:0]              gear,
	output logic                                    gear_changed,
	output logic [grd_pkg::SPEED_W-1:0]             speed_mph,
	output logic                                    speed_changed
);
	import grd_pkg::*;

	localparam int PW = CFG_W + RPM_BITS;
	localparam logic signed [RPM_BITS-1:0] SHAFT_MIN_V = RPM_BITS'(SHAFT_MIN);
	localparam logic [RPM_BITS-1:0]        WHEEL_MIN_V = RPM_BITS'(WHEEL_MIN);
	localparam logic [PW:0]                ROUND_HALF  = (PW+1)'(1) << (SPEED_FRAC - 1);

	logic [GEAR_W-1:0]  held_q;
	logic [GEAR_W-1:0]  cand_q;
	logic [TIME_W-1:0]  cand_since_q;
	logic [TIME_W-1:0]  last_conf_q;
	logic [SPEED_W-1:0] shown_q;
	logic               gear_chg_q;
	logic               speed_chg_q;

	logic [PW-1:0]       shaft_sc;
	logic                neutral;
	logic [GEAR_W-1:0]   detected;
	logic [TIME_W-1:0]   timeout;
	logic [TIME_W-1:0]   el_cand;
	logic [TIME_W-1:0]   el_last;
	logic [GEAR_W-1:0]   confirmed;
	logic                take_cand;
	logic                stamp_conf;
	logic [PW:0]         speed_sum;
	logic [RPM_BITS:0]   mph_full;
	logic [SPEED_W-1:0]  mph_sat;
	logic [SPEED_W-1:0]  new_speed;
	logic [SPEED_W-1:0]  speed_delta;

	function automatic logic ratio_ok(input logic [PW-1:0] a, input logic [PW-1:0] p,
	                                  input logic [PW-1:0] tol);
		logic [PW-1:0] d;
		d = (a >= p) ? a - p : p - a;
		return d <= tol;
	endfunction

	// shaft sign only matters below the neutral floor, so the low bits suffice
	assign shaft_sc = PW'({shaft_s2[RPM_BITS-2:0], {RATIO_FRAC{1'b0}}});
	assign neutral  = (shaft_s2 < SHAFT_MIN_V) || (mag_s2 < WHEEL_MIN_V);

	always_comb begin
		if (neutral)
			detected = GEAR_NEUTRAL;
		else if (wheel_neg_s2 && ratio_ok(shaft_sc, rev_prod_s2, tol_prod_s2))
			detected = GEAR_REVERSE;
		else if (ratio_ok(shaft_sc, first_prod_s2, tol_prod_s2))
			detected = GEAR_FIRST;
		else if (ratio_ok(shaft_sc, second_prod_s2, tol_prod_s2))
			detected = GEAR_SECOND;
		else if (ratio_ok(shaft_sc, third_prod_s2, tol_prod_s2))
			detected = GEAR_THIRD;
		else
			detected = GEAR_NEUTRAL;
	end

	assign timeout   = TIME_W'(cfg.stability_timeout_ms);
	assign el_cand   = now_s2 - cand_since_q;
	assign el_last   = now_s2 - last_conf_q;
	assign take_cand = (detected != cand_q);

	always_comb begin
		stamp_conf = 1'b0;
		confirmed  = held_q;
		if (!take_cand) begin
			if (el_cand >= timeout) begin
				confirmed  = cand_q;
				stamp_conf = 1'b1;
			end
		end else if (el_last > timeout) begin
			confirmed = GEAR_NEUTRAL;
		end
	end

	// round half up, then saturate
	assign speed_sum   = {1'b0, speed_prod_s2} + ROUND_HALF;
	assign mph_full    = speed_sum[PW:SPEED_FRAC];
	assign mph_sat     = (|mph_full[RPM_BITS:SPEED_W]) ? SPEED_MAX : mph_full[SPEED_W-1:0];
	assign new_speed   = wheel_pos_s2 ? mph_sat : '0;
	assign speed_delta = (new_speed >= shown_q) ? new_speed - shown_q : shown_q - new_speed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= GEAR_NEUTRAL;
			cand_q       <= GEAR_NEUTRAL;
			cand_since_q <= '0;
			last_conf_q  <= '0;
			shown_q      <= '0;
		end else if (ctrl.commit) begin
			held_q <= confirmed;
			if (take_cand) begin
				cand_q       <= detected;
				cand_since_q <= now_s2;
			end
			if (stamp_conf)
				last_conf_q <= now_s2;
			if (speed_delta > SPEED_W'(1))
				shown_q <= new_speed;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			gear_chg_q  <= (confirmed != held_q);
			speed_chg_q <= (speed_delta > SPEED_W'(1));
		end
	end

	assign gear          = held_q;
	assign gear_changed  = gear_chg_q;
	assign speed_mph     = shown_q;
	assign speed_changed = speed_chg_q;

	`GRD_ASSERT(a_gear_chg_flag, ctrl.commit |=> (gear_chg_q == (held_q != $past(held_q))), "gear_changed disagrees with held gear")
	`GRD_ASSERT(a_state_hold, !ctrl.commit |=> ($stable(held_q) && $stable(cand_q) && $stable(shown_q)), "state moved without a transaction")
	`GRD_ASSERT(a_speed_chg_flag, ctrl.commit |=> (speed_chg_q == (shown_q != $past(shown_q))), "speed_changed disagrees with shown speed")
	`GRD_ASSERT(a_gear_range, (held_q <= GEAR_THIRD) && (cand_q <= GEAR_THIRD), "gear code out of range")
endmodule

// ----- verif/gear_ratio_detector_checker.sv -----
`timescale 1ns / 1ps
module gear_ratio_detector_checker #(
	parameter int RPM_BITS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	grd_in_if                             sample,
	grd_out_if                            result,
	input  logic                          cfg_we,
	input  logic [grd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [grd_pkg::CFG_W-1:0]     cfg_data,
	output int                            errors,
	output int                            pending,
	output int                            gear_switches,
	output int                            speed_updates
);
	import grd_pkg::*;

	typedef struct packed {
		logic [GEAR_W-1:0]  gear;
		logic               gear_changed;
		logic [SPEED_W-1:0] speed_mph;
		logic               speed_changed;
	} reading_t;

	cfg_t               cfg;
	logic [GEAR_W-1:0]  held_gear;
	logic [GEAR_W-1:0]  candidate;
	logic [TIME_W-1:0]  candidate_since;
	logic [TIME_W-1:0]  last_confirmed;
	logic [SPEED_W-1:0] shown_speed;
	reading_t           readings_due[$];

	// |shaft * 4096 - ratio * |wheel|| <= tolerance * |wheel|
	function automatic logic ratio_fits(longint shaft, longint mag, logic [CFG_W-1:0] ratio);
		longint dev;
		dev = shaft * (longint'(1) << RATIO_FRAC) - longint'(ratio) * mag;
		if (dev < 0)
			dev = -dev;
		return dev <= longint'(cfg.ratio_tolerance) * mag;
	endfunction

	function automatic logic [GEAR_W-1:0] detect_gear(longint shaft, longint wheel);
		longint mag;
		mag = (wheel < 0) ? -wheel : wheel;
		if (shaft < SHAFT_MIN || mag < WHEEL_MIN)
			return GEAR_NEUTRAL;
		if (wheel < 0 && ratio_fits(shaft, mag, cfg.ratio_reverse))
			return GEAR_REVERSE;
		if (ratio_fits(shaft, mag, cfg.ratio_first))
			return GEAR_FIRST;
		if (ratio_fits(shaft, mag, cfg.ratio_second))
			return GEAR_SECOND;
		if (ratio_fits(shaft, mag, cfg.ratio_third))
			return GEAR_THIRD;
		return GEAR_NEUTRAL;
	endfunction

	function automatic logic [SPEED_W-1:0] road_speed(longint wheel);
		longint mph;
		if (wheel <= 0)
			return '0;
		mph = (wheel * longint'(cfg.speed_scale) + (longint'(1) << (SPEED_FRAC - 1)))
			>>> SPEED_FRAC;
		return (mph > longint'(SPEED_MAX)) ? SPEED_MAX : mph[SPEED_W-1:0];
	endfunction

	function automatic reading_t predict_reading(input logic signed [RPM_BITS-1:0] shaft_in,
			input logic signed [RPM_BITS-1:0] wheel_in, input logic [TIME_W-1:0] now);
		longint             shaft;
		longint             wheel;
		logic [GEAR_W-1:0]  seen;
		logic [GEAR_W-1:0]  confirmed;
		logic [SPEED_W-1:0] fresh;
		logic [SPEED_W-1:0] drift;
		reading_t           r;
		shaft = shaft_in;
		wheel = wheel_in;
		fresh = road_speed(wheel);
		seen = detect_gear(shaft, wheel);
		if (seen == candidate) begin
			if (now - candidate_since >= cfg.stability_timeout_ms) begin
				last_confirmed = now;
				confirmed = candidate;
			end else begin
				confirmed = held_gear;
			end
		end else begin
			// restart the stability window; fall back to neutral once nothing held long enough
			candidate = seen;
			candidate_since = now;
			confirmed = (now - last_confirmed > cfg.stability_timeout_ms) ? GEAR_NEUTRAL
				: held_gear;
		end
		r.speed_changed = 1'b0;
		drift = (fresh > shown_speed) ? fresh - shown_speed : shown_speed - fresh;
		if (drift > 1) begin
			shown_speed = fresh;
			r.speed_changed = 1'b1;
		end
		r.gear_changed = (confirmed != held_gear);
		held_gear = confirmed;
		r.gear = held_gear;
		r.speed_mph = shown_speed;
		return r;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			cfg = '{ratio_reverse: RST_RATIO_REVERSE, ratio_first: RST_RATIO_FIRST,
				ratio_second: RST_RATIO_SECOND, ratio_third: RST_RATIO_THIRD,
				ratio_tolerance: RST_RATIO_TOL, stability_timeout_ms: RST_TIMEOUT,
				speed_scale: RST_SPEED_SCALE};
			held_gear = GEAR_NEUTRAL;
			candidate = GEAR_NEUTRAL;
			candidate_since = '0;
			last_confirmed = '0;
			shown_speed = '0;
			readings_due.delete();
			errors = 0;
			pending = 0;
			gear_switches = 0;
			speed_updates = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (readings_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result transaction, expected none, actual gear %0d speed %0d",
						$time, result.gear, result.speed_mph);
				end else begin
					want = readings_due.pop_front();
					check_field("gear", want.gear, result.gear);
					check_field("gear_changed", want.gear_changed, result.gear_changed);
					check_field("speed_mph", want.speed_mph, result.speed_mph);
					check_field("speed_changed", want.speed_changed, result.speed_changed);
					if (want.gear_changed)
						gear_switches++;
					if (want.speed_changed)
						speed_updates++;
				end
			end
			if (sample.valid && sample.ready)
				readings_due.push_back(predict_reading(sample.shaft_rpm, sample.wheel_rpm,
					sample.now_ms));
			if (cfg_we) begin
				case (cfg_index)
					REG_RATIO_REVERSE: cfg.ratio_reverse = cfg_data;
					REG_RATIO_FIRST:   cfg.ratio_first = cfg_data;
					REG_RATIO_SECOND:  cfg.ratio_second = cfg_data;
					REG_RATIO_THIRD:   cfg.ratio_third = cfg_data;
					REG_RATIO_TOL:     cfg.ratio_tolerance = cfg_data;
					REG_TIMEOUT:       cfg.stability_timeout_ms = cfg_data;
					REG_SPEED_SCALE:   cfg.speed_scale = cfg_data;
					default: ;
				endcase
			end
			pending = readings_due.size();
		end
	end

endmodule

// ----- verif/gear_ratio_detector_top_tb.sv -----
`timescale 1ns / 1ps
module gear_ratio_detector_top_tb;
	import grd_pkg::*;

	localparam int RPM_BITS = 14;
	localparam int LATENCY = 3;
	localparam int SETTLE = 4 * LATENCY + 4;
	localparam int PHASE_SAMPLES = 140;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	int errors;
	int pending;
	int gear_switches;
	int speed_updates;
	int in_idle_pct = 0;
	int out_stall_pct = 0;
	int samples_sent = 0;
	int settings_used = 1;

	logic [TIME_W-1:0] clock_ms;
	logic [CFG_W-1:0]  reg_shadow [0:6];

	grd_in_if #(.RPM_BITS(RPM_BITS)) sample();
	grd_out_if result();

	gear_ratio_detector_top #(.RPM_BITS(RPM_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	gear_ratio_detector_checker #(.RPM_BITS(RPM_BITS)) gear_watch (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending),
		.gear_switches(gear_switches),
		.speed_updates(speed_updates)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			result.ready <= ($urandom_range(99) >= out_stall_pct);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Timeout after %0d cycles with %0d results outstanding", CYCLE_LIMIT, pending);
		$display("Simulation FAILED");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx != REG_UNUSED)
			reg_shadow[idx] = value;
	endtask

	task automatic apply_settings(input logic [CFG_W-1:0] rev, input logic [CFG_W-1:0] first,
			input logic [CFG_W-1:0] second, input logic [CFG_W-1:0] third,
			input logic [CFG_W-1:0] tol, input logic [CFG_W-1:0] timeout,
			input logic [CFG_W-1:0] scale);
		write_reg(REG_RATIO_REVERSE, rev);
		write_reg(REG_RATIO_FIRST, first);
		write_reg(REG_RATIO_SECOND, second);
		write_reg(REG_RATIO_THIRD, third);
		write_reg(REG_RATIO_TOL, tol);
		write_reg(REG_TIMEOUT, timeout);
		write_reg(REG_SPEED_SCALE, scale);
		// no register behind this index: must leave everything unchanged
		write_reg(REG_UNUSED, CFG_W'($urandom));
		settings_used++;
	endtask

	task automatic send_sample(input logic signed [RPM_BITS-1:0] shaft,
			input logic signed [RPM_BITS-1:0] wheel, input logic [TIME_W-1:0] step);
		clock_ms += step;
		while ($urandom_range(99) < in_idle_pct) begin
			@(negedge clk);
			sample.valid <= 1'b0;
		end
		@(negedge clk);
		sample.valid <= 1'b1;
		sample.shaft_rpm <= shaft;
		sample.wheel_rpm <= wheel;
		sample.now_ms <= clock_ms;
		do @(posedge clk); while (!sample.ready);
		samples_sent++;
	endtask

	task automatic wait_drain();
		@(negedge clk);
		sample.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Build a sample whose ratio sits near the configured one for a driving gear, close
	// to the tolerance edge so both sides get hit; neutral gets a shaft below 100 rpm.
	task automatic make_gear_sample(input logic [GEAR_W-1:0] gear,
			output logic signed [RPM_BITS-1:0] shaft, output logic signed [RPM_BITS-1:0] wheel);
		longint ratio;
		longint mag;
		longint hi;
		longint spread;
		longint s;
		if (gear == GEAR_NEUTRAL) begin
			shaft = RPM_BITS'(longint'($urandom_range(299)) - 200);
			wheel = RPM_BITS'($urandom);
		end else begin
			case (gear)
				GEAR_REVERSE: ratio = reg_shadow[REG_RATIO_REVERSE];
				GEAR_FIRST:   ratio = reg_shadow[REG_RATIO_FIRST];
				GEAR_SECOND:  ratio = reg_shadow[REG_RATIO_SECOND];
				default:      ratio = reg_shadow[REG_RATIO_THIRD];
			endcase
			hi = (ratio == 0) ? 8191 : (8191 * 4096) / ratio;
			if (hi > 8191)
				hi = 8191;
			if (hi < 10)
				hi = 10;
			if ($urandom_range(1) == 0 && hi > 400)
				hi = 400;
			mag = $urandom_range(int'(hi), 10);
			spread = (longint'(reg_shadow[REG_RATIO_TOL]) * mag) >>> RATIO_FRAC;
			s = ((ratio * mag + 2048) >>> RATIO_FRAC) + $urandom_range(int'(2 * spread + 2))
				- (spread + 1);
			if (s > 8191)
				s = 8191;
			if (s < -8192)
				s = -8192;
			shaft = RPM_BITS'(s);
			// forward gears are matched whatever the wheel sign
			if (gear == GEAR_REVERSE || $urandom_range(4) == 0)
				mag = -mag;
			wheel = RPM_BITS'(mag);
		end
	endtask

	task automatic random_run();
		int                         kind;
		int                         pace;
		logic [GEAR_W-1:0]          gear;
		logic signed [RPM_BITS-1:0] shaft;
		logic signed [RPM_BITS-1:0] wheel;
		pace = reg_shadow[REG_TIMEOUT] / 3 + 5;
		kind = $urandom_range(99);
		if (kind < 75) begin
			gear = GEAR_W'($urandom_range(GEAR_THIRD));
			repeat ($urandom_range(10, 2)) begin
				make_gear_sample(gear, shaft, wheel);
				send_sample(shaft, wheel, $urandom_range(pace));
			end
		end else if (kind < 92) begin
			send_sample(RPM_BITS'($urandom), RPM_BITS'($urandom), $urandom_range(pace));
		end else begin
			// jump the clock anywhere, wrap included
			send_sample(RPM_BITS'($urandom), RPM_BITS'($urandom), $urandom);
		end
	endtask

	initial begin
		int target;
		sample.valid = 1'b0;
		sample.shaft_rpm = '0;
		sample.wheel_rpm = '0;
		sample.now_ms = '0;
		clock_ms = '0;
		reg_shadow[REG_RATIO_REVERSE] = RST_RATIO_REVERSE;
		reg_shadow[REG_RATIO_FIRST] = RST_RATIO_FIRST;
		reg_shadow[REG_RATIO_SECOND] = RST_RATIO_SECOND;
		reg_shadow[REG_RATIO_THIRD] = RST_RATIO_THIRD;
		reg_shadow[REG_RATIO_TOL] = RST_RATIO_TOL;
		reg_shadow[REG_TIMEOUT] = RST_TIMEOUT;
		reg_shadow[REG_SPEED_SCALE] = RST_SPEED_SCALE;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// extremes and thresholds at the reset settings
		send_sample(0, 0, 0);
		send_sample(8191, 8191, 10);
		send_sample(-8192, -8192, 10);
		send_sample(99, 100, 10);
		send_sample(100, 9, 10);
		send_sample(100, -10, 10);
		repeat (3) send_sample(1032, -300, 300);
		repeat (3) send_sample(1032, 300, 300);
		repeat (3) send_sample(663, 300, 300);
		repeat (3) send_sample(411, -300, 300);
		// first gear ratio right at and just past the tolerance edge
		send_sample(3540, 1000, 100);
		send_sample(3541, 1000, 100);
		send_sample(50, 13, 100);
		send_sample(50, 14, 100);
		// run the timestamp across the wrap
		clock_ms = 32'hFFFF_FE00;
		repeat (3) send_sample(663, 300, 300);
		wait_drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					in_idle_pct = 0;
					out_stall_pct = 0;
				end
				1: begin
					apply_settings(16'hFFFF, 16'd8192, 16'd4096, 16'd0, 16'd0, 16'd0, 16'hFFFF);
					in_idle_pct = 45;
					out_stall_pct = 0;
				end
				2: begin
					apply_settings(16'd0, 16'd1, 16'hFFFF, 16'd12288, 16'hFFFF, 16'hFFFF, 16'd0);
					in_idle_pct = 0;
					out_stall_pct = 45;
				end
				3: begin
					apply_settings(CFG_W'($urandom_range(20000, 2000)),
						CFG_W'($urandom_range(20000, 2000)),
						CFG_W'($urandom_range(20000, 2000)),
						CFG_W'($urandom_range(20000, 2000)),
						CFG_W'($urandom_range(1000, 50)), CFG_W'($urandom_range(1000)),
						CFG_W'($urandom));
					in_idle_pct = 28;
					out_stall_pct = 28;
				end
				4: begin
					apply_settings(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
						CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
					in_idle_pct = 45;
					out_stall_pct = 0;
				end
				default: begin
					apply_settings(RST_RATIO_REVERSE, RST_RATIO_FIRST, RST_RATIO_SECOND,
						RST_RATIO_THIRD, RST_RATIO_TOL, RST_TIMEOUT, RST_SPEED_SCALE);
					in_idle_pct = 0;
					out_stall_pct = 0;
				end
			endcase
			target = samples_sent + PHASE_SAMPLES;
			while (samples_sent < target)
				random_run();
			wait_drain();
		end

		$display("Ran %0d sample transactions under %0d register settings with four idle patterns.",
			samples_sent, settings_used);
		$display("Observed %0d confirmed gear changes and %0d speed display updates.",
			gear_switches, speed_updates);
		if (errors == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
